// ----- src/gamepad_expo_drive_mapper_unit_assert.svh -----
// Assertion macros for the drive mapper.
// Both sample on i_clk and are held off during reset.
`ifndef GAMEPAD_EXPO_DRIVE_MAPPER_UNIT_ASSERT_SVH
`define GAMEPAD_EXPO_DRIVE_MAPPER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GEDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GEDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/gedm_pkg.sv -----
// ----------------------------------------------------------------------------
// gedm_pkg
// Shared types, constants and root table of the drive mapper.
// ----------------------------------------------------------------------------
package gedm_pkg;

    localparam int unsigned KICK_INTERVAL_DEF = 300;

    localparam logic [15:0] DB_MAX_Q16      = 16'd62259;  // 0.95
    localparam logic [14:0] EXPO_MIN_Q12    = 15'd410;    // 0.1
    localparam logic [7:0]  REPORT_ENHANCED = 8'h31;
    localparam logic [7:0]  HEADER_PREFIX   = 8'hA1;

    typedef enum logic [1:0] {
        REG_DEADBAND  = 2'd0,
        REG_EXPO      = 2'd1,
        REG_MAX_SPEED = 2'd2,
        REG_MAX_TURN  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        L_IDLE,
        L_MID,
        L_DIV2,
        L_NORM,
        L_LOG,
        L_EXPO,
        L_EXP,
        L_FIN,
        L_SCALE
    } t_lane_state;

    // Per-lane settings; deadband and expo already clamped.
    typedef struct packed {
        logic [15:0] db;
        logic [14:0] expo;
        logic [15:0] limit;
    } t_lane_cfg;

    // exp2 roots 2^(-2^-i), i = 1..16, in Q30
    typedef logic [15:0][29:0] t_roots;

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        bitv = 64'd1 << 62;
        rem  = n;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_roots build_roots();
        t_roots      r;
        logic [63:0] prev;
        prev = isqrt(64'd1 << 59);
        r[0] = prev[29:0];
        for (int k = 1; k < 16; k++) begin
            prev = isqrt(prev << 30);
            r[k] = prev[29:0];
        end
        return r;
    endfunction

    localparam t_roots EXP_ROOTS = build_roots();

endpackage

// ----- src/gedm_lane.sv -----
// ----------------------------------------------------------------------------
// gedm_lane
// One stick axis: deadband remap, log2/exp2 expo curve, limit scaling.
// ----------------------------------------------------------------------------
module gedm_lane
    import gedm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [7:0]      i_mag,
    input  logic            i_neg,
    input  t_lane_cfg       i_cfg,
    output logic            o_busy,
    output logic [16:0]     o_target
);

    t_lane_state r_state, n_state;
    logic [5:0]  r_cnt;
    logic [16:0] r_rem;
    logic [32:0] r_quo;
    logic [16:0] r_den;
    logic        r_neg;
    logic [30:0] r_x;
    logic [4:0]  r_p;
    logic [15:0] r_f;
    logic [23:0] r_y;
    logic [30:0] r_res;
    logic [16:0] r_curve;
    logic [16:0] r_target;

    // decoded controls
    logic div_run;
    logic div_last;
    logic loop_last;

    // a = floor((m*2^16+127)/254) = 258*m plus 0..2 from (2m+63)/127
    logic [8:0]  mag_s;
    logic [15:0] a_q;
    always_comb begin
        mag_s = {i_mag, 1'b0} + 9'd63;
        a_q   = ({8'b0, i_mag} << 8) + ({8'b0, i_mag} << 1)
              + ((mag_s >= 9'd254) ? 16'd2 : (mag_s >= 9'd127) ? 16'd1 : 16'd0);
    end

    // divider step
    logic [17:0] rem_sh;
    logic        ge;
    always_comb begin
        rem_sh = {r_rem, r_quo[32]};
        ge     = rem_sh >= {1'b0, r_den};
    end

    // deadband check
    logic [16:0] a2;
    logic        below_db;
    always_comb begin
        a2       = {r_quo[15:0], 1'b0};
        below_db = a2 <= {1'b0, i_cfg.db};
    end

    // normalize
    logic [16:0] rr;
    logic [4:0]  msb;
    logic [30:0] xn;
    always_comb begin
        rr  = (r_quo > 33'd65536) ? 17'h10000 : r_quo[16:0];
        msb = '0;
        for (int k = 0; k < 17; k++) begin
            if (rr[k]) msb = 5'(k);
        end
        xn = {14'b0, rr} << (5'd30 - msb);
    end

    // log squaring
    logic [61:0] sq;
    logic [31:0] x2;
    always_comb begin
        sq = {31'b0, r_x} * {31'b0, r_x};
        x2 = sq[61:30];
    end

    // y = L * e in Q16
    logic [20:0] lq;
    logic [35:0] ly;
    always_comb begin
        lq = {(5'd16 - r_p), 16'b0} - {5'b0, r_f};
        ly = {15'b0, lq} * {21'b0, i_cfg.expo} + 36'd2048;
    end

    // exp2 step
    logic [61:0] ep;
    always_comb begin
        ep = {31'b0, r_res} * {32'b0, EXP_ROOTS[r_cnt[3:0]]} + (62'd1 << 29);
    end

    // final shift and round
    logic [30:0] shr;
    logic [31:0] rnd;
    always_comb begin
        shr = r_res >> r_y[20:16];
        rnd = {1'b0, shr} + 32'd8192;
    end

    // limit scaling
    logic [33:0] tp;
    logic [17:0] t;
    logic [16:0] tc;
    always_comb begin
        tp = {17'b0, r_curve} * {18'b0, i_cfg.limit} + 34'd32768;
        t  = tp[33:16];
        tc = (t > {2'b0, i_cfg.limit}) ? {1'b0, i_cfg.limit} : t[16:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE:  if (i_start) n_state = L_MID;
            L_MID:   n_state = below_db ? L_IDLE : L_DIV2;
            L_DIV2:  if (div_last) n_state = L_NORM;
            L_NORM:  n_state = (rr == '0) ? L_IDLE : L_LOG;
            L_LOG:   if (loop_last) n_state = L_EXPO;
            L_EXPO:  n_state = L_EXP;
            L_EXP:   if (loop_last) n_state = L_FIN;
            L_FIN:   n_state = L_SCALE;
            L_SCALE: n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    // outputs and controls
    always_comb begin
        o_busy    = r_state != L_IDLE;
        div_run   = r_state == L_DIV2;
        div_last  = r_cnt == 6'd32;
        loop_last = r_cnt == 6'd15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_run) begin
            r_rem <= ge ? 17'(rem_sh - {1'b0, r_den}) : rem_sh[16:0];
            r_quo <= {r_quo[31:0], ge};
            r_cnt <= r_cnt + 6'd1;
        end
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_quo <= {17'b0, a_q};
                    r_neg <= i_neg;
                end
            end
            L_MID: begin
                if (below_db) begin
                    r_target <= '0;
                end
                r_quo <= {17'(a2 - {1'b0, i_cfg.db}), 16'b0};
                r_rem <= '0;
                r_den <= 17'h10000 - {1'b0, i_cfg.db};
                r_cnt <= '0;
            end
            L_NORM: begin
                if (rr == '0) begin
                    r_target <= '0;
                end
                r_x   <= xn;
                r_p   <= msb;
                r_f   <= '0;
                r_cnt <= '0;
            end
            L_LOG: begin
                if (x2[31]) begin
                    r_x <= x2[31:1];
                    r_f <= {r_f[14:0], 1'b1};
                end else begin
                    r_x <= x2[30:0];
                    r_f <= {r_f[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
            end
            L_EXPO: begin
                r_y   <= ly[35:12];
                r_res <= 31'h4000_0000;
                r_cnt <= '0;
            end
            L_EXP: begin
                if (r_y[4'd15 - r_cnt[3:0]]) begin
                    r_res <= ep[60:30];
                end
                r_cnt <= r_cnt + 6'd1;
            end
            L_FIN: begin
                r_curve <= (r_y[23:16] > 8'd30) ? 17'd0 : rnd[30:14];
            end
            L_SCALE: begin
                r_target <= r_neg ? 17'(17'd0 - tc) : tc;
            end
            default: begin
            end
        endcase
    end

    assign o_target = r_target;

endmodule

// ----- src/gamepad_expo_drive_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// gamepad_expo_drive_mapper_unit
// Maps controller packets to speed and turn targets with deadband and expo.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one controller packet per
//   transfer. Output channel (o_valid / i_stall) carries one result per
//   packet, in order. Settings sit on an APB-style port at 4*index.
//   Report 0x31 packets run two lanes side by side, one per stick axis;
//   each lane gets the Q1.15 stick value by a constant multiply and
//   compare, then runs a shift-and-subtract divider, 16 log2 squarings
//   and 16 exp2 multiplies, then scales to the limit. A lane whose stick
//   sits in the deadband gives zero and skips the divider and curve.
//   Other packets only run the kick timer.
//   One packet is in work at a time; o_stall is high from the transfer
//   until its result moves into the output register, so the next packet
//   can follow in the cycle after that.
//   The output register lets the next packet enter while the previous
//   result waits. If the receiver stalls, the finished lane results wait
//   and the block holds o_stall until the output register frees up.
//   Reset clears the kick timestamp, auto-arm, the settings (expo 1.0)
//   and all valid flags.
// ----------------------------------------------------------------------------
`include "gamepad_expo_drive_mapper_unit_assert.svh"

module gamepad_expo_drive_mapper_unit
    import gedm_pkg::*;
#(
    parameter int unsigned KICK_INTERVAL_MS = KICK_INTERVAL_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_packet_present,
    input  logic [7:0]         i_header_byte,
    input  logic [7:0]         i_second_byte,
    input  logic signed [7:0]  i_left_stick_y,
    input  logic signed [7:0]  i_right_stick_x,
    input  logic               i_btn_ps_edge,
    input  logic               i_btn_share_edge,
    input  logic               i_btn_square_edge,
    input  logic [31:0]        i_now_ms,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_report_ok,
    output logic               o_kick_request,
    output logic signed [16:0] o_speed_target,
    output logic signed [16:0] o_turn_target,
    output logic               o_reset_request,
    output logic               o_disarm_request,
    output logic               o_page_request,
    output logic               o_auto_arm
);

    localparam logic [31:0] KICK_LIM = 32'(KICK_INTERVAL_MS);

    // ---------------- configuration registers ----------------
    logic [15:0] r_deadband;
    logic [14:0] r_expo;
    logic [15:0] r_max_speed;
    logic [15:0] r_max_turn;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband  <= '0;
            r_expo      <= 15'd4096;
            r_max_speed <= '0;
            r_max_turn  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEADBAND:  r_deadband  <= pwdata[15:0];
                REG_EXPO:      r_expo      <= pwdata[14:0];
                REG_MAX_SPEED: r_max_speed <= pwdata[15:0];
                REG_MAX_TURN:  r_max_turn  <= pwdata[15:0];
                default:       r_deadband  <= r_deadband;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DEADBAND:  prdata = {16'b0, r_deadband};
            REG_EXPO:      prdata = {17'b0, r_expo};
            REG_MAX_SPEED: prdata = {16'b0, r_max_speed};
            REG_MAX_TURN:  prdata = {16'b0, r_max_turn};
            default:       prdata = '0;
        endcase
    end

    // clamped curve settings, shared by both lanes
    logic [15:0] db_c;
    logic [14:0] expo_c;
    t_lane_cfg   cfg_speed, cfg_turn;
    always_comb begin
        db_c   = (r_deadband > DB_MAX_Q16) ? DB_MAX_Q16 : r_deadband;
        expo_c = (r_expo < EXPO_MIN_Q12) ? EXPO_MIN_Q12 : r_expo;
        cfg_speed = '{db: db_c, expo: expo_c, limit: r_max_speed};
        cfg_turn  = '{db: db_c, expo: expo_c, limit: r_max_turn};
    end

    // ---------------- input decode ----------------
    logic       in_xfer;
    logic [7:0] report_id;
    logic       id_ok;
    logic [7:0] spd_mag, trn_mag;
    logic       spd_neg, trn_neg;

    assign in_xfer = i_valid && !o_stall;

    always_comb begin
        report_id = '0;
        if (i_packet_present) begin
            report_id = (i_header_byte == HEADER_PREFIX) ? i_second_byte : i_header_byte;
        end
        id_ok = report_id == REPORT_ENHANCED;
        // speed uses the negated left Y
        spd_neg = i_left_stick_y > 8'sd0;
        spd_mag = i_left_stick_y[7] ? 8'(-i_left_stick_y) : i_left_stick_y;
        trn_neg = i_right_stick_x[7];
        trn_mag = i_right_stick_x[7] ? 8'(-i_right_stick_x) : i_right_stick_x;
    end

    // ---------------- lanes ----------------
    logic        lane_start;
    logic        spd_busy, trn_busy;
    logic [16:0] spd_target, trn_target;

    assign lane_start = in_xfer && id_ok;

    gedm_lane u_lane_speed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lane_start),
        .i_mag    (spd_mag),
        .i_neg    (spd_neg),
        .i_cfg    (cfg_speed),
        .o_busy   (spd_busy),
        .o_target (spd_target)
    );

    gedm_lane u_lane_turn (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lane_start),
        .i_mag    (trn_mag),
        .i_neg    (trn_neg),
        .i_cfg    (cfg_turn),
        .o_busy   (trn_busy),
        .o_target (trn_target)
    );

    // ---------------- packet in work ----------------
    logic        r_busy;
    logic        r_ok;
    logic        r_ps, r_share, r_square;
    logic [31:0] r_now;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ok     <= id_ok;
            r_ps     <= i_btn_ps_edge;
            r_share  <= i_btn_share_edge;
            r_square <= i_btn_square_edge;
            r_now    <= i_now_ms;
        end
    end

    // ---------------- merge into output register ----------------
    logic        r_out_valid;
    logic        r_report_ok, r_kick, r_reset_rq, r_disarm_rq, r_page_rq, r_arm_out;
    logic [16:0] r_speed, r_turn;
    logic [31:0] r_last_kick;
    logic        r_auto_arm;
    logic        unload;
    logic        kick_due;
    logic        arm_next;

    assign unload = r_busy && !spd_busy && !trn_busy && (!r_out_valid || !i_stall);

    always_comb begin
        kick_due = !r_ok && ((r_now - r_last_kick) > KICK_LIM);
        arm_next = r_auto_arm;
        if (r_ok && r_ps)    arm_next = 1'b1;
        if (r_ok && r_share) arm_next = 1'b0;  // Share wins over PS
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_kick <= '0;
            r_auto_arm  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_busy <= 1'b1;
            end else if (unload) begin
                r_busy <= 1'b0;
            end
            if (unload) begin
                r_out_valid <= 1'b1;
                r_auto_arm  <= arm_next;
                if (kick_due) begin
                    r_last_kick <= r_now;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (unload) begin
            r_report_ok <= r_ok;
            r_kick      <= kick_due;
            r_speed     <= r_ok ? spd_target : 17'd0;
            r_turn      <= r_ok ? trn_target : 17'd0;
            r_reset_rq  <= r_ok && r_ps;
            r_disarm_rq <= r_ok && r_share;
            r_page_rq   <= r_ok && r_square;
            r_arm_out   <= arm_next;
        end
    end

    assign o_stall          = r_busy;
    assign o_valid          = r_out_valid;
    assign o_report_ok      = r_report_ok;
    assign o_kick_request   = r_kick;
    assign o_speed_target   = r_speed;
    assign o_turn_target    = r_turn;
    assign o_reset_request  = r_reset_rq;
    assign o_disarm_request = r_disarm_rq;
    assign o_page_request   = r_page_rq;
    assign o_auto_arm       = r_arm_out;

    // ---------------- assertions ----------------
    logic tgt_zero;
    logic both_rq;
    assign tgt_zero = (o_speed_target == 17'sd0) && (o_turn_target == 17'sd0);
    assign both_rq  = o_valid && o_reset_request && o_disarm_request;

    `GEDM_ASSERT_NOW(a_zero_targets, o_valid && !o_report_ok, tgt_zero, "target on bad report")
    `GEDM_ASSERT_NOW(a_kick_only_rejected, o_valid && o_kick_request, !o_report_ok, "good kick")
    `GEDM_ASSERT_NOW(a_share_wins, both_rq, !o_auto_arm, "auto-arm set with share edge")
    `GEDM_ASSERT_NEXT(a_one_in_work, i_valid && !o_stall, o_stall, "packet taken while busy")

endmodule
